// ===== src/cfd_pkg.sv =====
// Package for the frame decoder: types, constants and helper functions.
// Depends on nothing; every other file of the block imports it.
package cfd_pkg;

  // Sizes of the stores and the derived widths.
  localparam int CODEBOOK_ENTRIES = 256;
  localparam int FB_WORDS         = 131072;
  localparam int CB_AW            = $clog2(CODEBOOK_ENTRIES);
  localparam int CY_W             = $clog2(FB_WORDS) + 1;
  localparam int ADDR_W           = CY_W + 9;
  localparam int CMDQ_DEPTH       = 4;
  localparam int OUTQ_DEPTH       = 4;

  localparam logic [7:0]  PITCH_RESET    = 8'd160;
  localparam logic [15:0] STRIP_ID_KEY   = 16'h1000;
  localparam logic [15:0] STRIP_ID_INTER = 16'h1100;
  localparam int          KIND_GREY_BIT  = 10;
  localparam int          KIND_V1_BIT    = 9;

  // Result kinds.
  localparam logic [1:0] RK_WRITE  = 2'd0;
  localparam logic [1:0] RK_STATUS = 2'd1;
  localparam logic [1:0] RK_DONE   = 2'd2;

  typedef enum logic [2:0] {
    SC_OK           = 3'd0,
    SC_BAD_STRIP    = 3'd1,
    SC_SHORT        = 3'd2,
    SC_LONG         = 3'd3,
    SC_UNKNOWN      = 3'd4,
    SC_LEN_MISMATCH = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    PH_FRAME_HDR  = 4'd0,
    PH_STRIP_HDR  = 4'd1,
    PH_CHUNK_HDR  = 4'd2,
    PH_FLAGS      = 4'd3,
    PH_V4_FLAGS   = 4'd4,
    PH_ENTRY      = 4'd5,
    PH_V1         = 4'd6,
    PH_V4         = 4'd7,
    PH_CHUNK_SKIP = 4'd8,
    PH_STRIP_SKIP = 4'd9,
    PH_FRAME_TAIL = 4'd10,
    PH_FRAME_OVER = 4'd11
  } phase_t;

  typedef enum logic [2:0] {
    CL_UNKNOWN = 3'd0,
    CL_FULL    = 3'd1,
    CL_PART    = 3'd2,
    CL_INTRA   = 3'd3,
    CL_INTER   = 3'd4,
    CL_V1ONLY  = 3'd5
  } cls_t;

  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_CBW  = 2'd1,
    OP_V1   = 2'd2,
    OP_V4   = 2'd3
  } cmd_op_t;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_ROWS = 2'd1,
    BK_STAT = 2'd2,
    BK_END  = 2'd3
  } bk_state_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [16:0] word_addr;
    logic [63:0] pixel_word;
    logic [2:0]  status_code;
    logic        last_of_run;
  } out_item_t;

  // One unit of work handed from the parser to the executing back end.
  typedef struct packed {
    cmd_op_t          op;
    logic             to_v1;
    logic             grey;
    logic [CB_AW-1:0] idx;
    logic [47:0]      data;
    logic [16:0]      cx;
    logic [CY_W-1:0]  cy;
    logic             stat_vld;
    status_t          stat_code;
    logic             end_vld;
    logic             end_done;
  } cmd_t;

  // Classify a chunk id.
  function automatic cls_t kind_class(input logic [15:0] id);
    cls_t c;
    c = CL_UNKNOWN;
    if (id[7:0] == 8'h00) begin
      if (id[15:8] inside {[8'h20:8'h27]}) c = id[8] ? CL_PART : CL_FULL;
      else if (id[15:8] == 8'h30) c = CL_INTRA;
      else if (id[15:8] == 8'h31) c = CL_INTER;
      else if (id[15:8] == 8'h32) c = CL_V1ONLY;
    end
    return c;
  endfunction

  // Convert one Y/U/V triple to a clamped RGB565 pixel.
  function automatic logic [15:0] yuv565(input logic [7:0] y, input logic [7:0] u,
                                         input logic [7:0] v);
    logic signed [10:0] ys;
    logic signed [10:0] us;
    logic signed [10:0] vs;
    logic signed [10:0] r;
    logic signed [10:0] g;
    logic signed [10:0] b;
    logic [7:0] rc;
    logic [7:0] gc;
    logic [7:0] bc;
    ys = {3'b000, y};
    us = {{3{u[7]}}, u};
    vs = {{3{v[7]}}, v};
    r  = ys + (vs <<< 1);
    g  = ys - (us >>> 1) - vs;
    b  = ys + (us <<< 1);
    rc = (r < 0) ? 8'd0 : ((r > 11'sd255) ? 8'd255 : r[7:0]);
    gc = (g < 0) ? 8'd0 : ((g > 11'sd255) ? 8'd255 : g[7:0]);
    bc = (b < 0) ? 8'd0 : ((b > 11'sd255) ? 8'd255 : b[7:0]);
    return {rc[7:3], gc[7:2], bc[7:3]};
  endfunction

endpackage

// ===== src/cfd_cmd_queue.sv =====
// Command queue between the parser front end and the back end.
// Depends on cfd_pkg for cmd_t and the queue depth.
module cfd_cmd_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  cfd_pkg::cmd_t wr_cmd,
  output logic          q_full,
  input  logic          rd_en,
  output cfd_pkg::cmd_t rd_cmd,
  output logic          q_empty
);
  import cfd_pkg::*;

  localparam int PW = $clog2(CMDQ_DEPTH);
  localparam int CW = $clog2(CMDQ_DEPTH + 1);

  cmd_t          mem_r [CMDQ_DEPTH];
  logic [PW-1:0] wp_r, wp_nxt;
  logic [PW-1:0] rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_wr, do_rd;

  // Status flags and head entry.
  always_comb begin
    q_full  = (cnt_r == CW'(CMDQ_DEPTH));
    q_empty = (cnt_r == '0);
    rd_cmd  = mem_r[rp_r];
    do_wr   = wr_en && !q_full;
    do_rd   = rd_en && !q_empty;
  end

  // Pointer and count updates.
  always_comb begin
    wp_nxt  = do_wr ? wp_r + PW'(1) : wp_r;
    rp_nxt  = do_rd ? rp_r + PW'(1) : rp_r;
    cnt_nxt = cnt_r + CW'(do_wr) - CW'(do_rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wp_r] <= wr_cmd;
  end

endmodule

// ===== src/cfd_front.sv =====
// Parser front end: takes chunk bytes, tracks headers and cursors, and issues
// commands to the back end. Depends on cfd_pkg.
module cfd_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  cfd_pkg::in_item_t in_item,
  output logic              cmd_push,
  output cfd_pkg::cmd_t     cmd,
  input  logic              cmd_full
);
  import cfd_pkg::*;

  typedef struct packed {
    phase_t          p;
    logic [47:0]     fc;
    logic [3:0]      bif;
    logic [15:0]     sl;
    logic [15:0]     sbl;
    logic [15:0]     ck;
    logic [15:0]     cbl;
    logic [63:0]     sb;
    logic [15:0]     rs;
    logic [16:0]     cx;
    logic [CY_W-1:0] cy;
    logic [31:0]     fb;
    logic [5:0]      fr;
    logic [CB_AW:0]  ci;
  } pstate_t;

  pstate_t st_r, st_nxt;
  logic    walk_r, walk_nxt;
  logic    accept;
  logic    emit_c;
  cmd_t    cmd_c;

  function automatic pstate_t f_reset();
    pstate_t s;
    s   = '0;
    s.p = PH_FRAME_HDR;
    return s;
  endfunction

  function automatic pstate_t f_strip_end(input pstate_t si, input logic stack);
    pstate_t s;
    s = si;
    if (stack) s.rs = s.rs + s.sb[31:16] - s.sb[63:48];
    if (s.sl != '0) s.sl = s.sl - 16'd1;
    s.bif = '0;
    s.p   = (s.sl != '0) ? PH_STRIP_HDR : PH_FRAME_TAIL;
    return s;
  endfunction

  function automatic pstate_t f_chunk_end(input pstate_t si);
    pstate_t s;
    s = si;
    if (s.sbl == '0) s = f_strip_end(s, 1'b1);
    else begin
      s.p   = PH_CHUNK_HDR;
      s.bif = '0;
    end
    return s;
  endfunction

  function automatic pstate_t f_skip_or_end(input pstate_t si);
    pstate_t s;
    s = si;
    if (s.sbl == '0) s = f_strip_end(s, 1'b0);
    else s.p = PH_STRIP_SKIP;
    return s;
  endfunction

  // Step the block cursor; rows past the framebuffer stop counting.
  function automatic pstate_t f_advance(input pstate_t si);
    pstate_t s;
    s    = si;
    s.cx = s.cx + 17'd4;
    if (s.cx >= {1'b0, s.sb[15:0]}) begin
      s.cx = {1'b0, s.sb[47:32]};
      if (32'(s.cy) < 32'(FB_WORDS)) s.cy = s.cy + CY_W'(4);
    end
    return s;
  endfunction

  assign accept = push && !full;

  // Next parser state and the command for this byte or walk step.
  always_comb begin : parse_next
    pstate_t     s;
    logic [15:0] id;
    logic [15:0] n;
    logic [7:0]  b;
    logic [3:0]  size;
    logic        pb;
    logic        nb;
    logic [16:0] sum;
    s        = st_r;
    id       = '0;
    n        = '0;
    b        = in_item.data_byte;
    size     = 4'd6;
    pb       = 1'b0;
    nb       = 1'b0;
    sum      = '0;
    cmd_c    = '0;
    emit_c   = 1'b0;
    walk_nxt = walk_r;

    if (walk_r) begin
      // Flag walk: consume flag bits to choose the next block or entry; input is held.
      walk_nxt = 1'b0;
      s.bif    = '0;
      case (kind_class(s.ck))
        CL_PART: begin
          if (s.fr != '0) begin
            pb   = s.fb[31];
            s.fb = {s.fb[30:0], 1'b0};
            s.fr = s.fr - 6'd1;
            if (pb) s.p = PH_ENTRY;
            else begin
              if (s.ci < (CB_AW + 1)'(CODEBOOK_ENTRIES)) s.ci = s.ci + 1'b1;
              walk_nxt = 1'b1;
            end
          end else begin
            s.p = PH_FLAGS;
          end
        end
        CL_INTRA: begin
          if (s.fr == '0) s.p = PH_FLAGS;
          else begin
            pb   = s.fb[31];
            s.fb = {s.fb[30:0], 1'b0};
            s.fr = s.fr - 6'd1;
            s.p  = pb ? PH_V4 : PH_V1;
          end
        end
        CL_INTER: begin
          if (s.fr == '0) s.p = PH_FLAGS;
          else begin
            pb   = s.fb[31];
            s.fb = {s.fb[30:0], 1'b0};
            s.fr = s.fr - 6'd1;
            if (!pb) begin
              s        = f_advance(s);
              walk_nxt = 1'b1;
            end else if (s.fr == '0) begin
              s.p = PH_V4_FLAGS;
            end else begin
              pb   = s.fb[31];
              s.fb = {s.fb[30:0], 1'b0};
              s.fr = s.fr - 6'd1;
              s.p  = pb ? PH_V4 : PH_V1;
            end
          end
        end
        CL_V1ONLY: s.p = PH_V1;
        default:   s.p = PH_CHUNK_SKIP;
      endcase
    end else if (accept) begin
      if (in_item.first_byte) s = f_reset();
      size = s.ck[KIND_GREY_BIT] ? 4'd4 : 4'd6;
      case (s.p)
        PH_FRAME_HDR: begin
          s.fc = {s.fc[39:0], b};
          if (s.bif == 4'd9) s.sl = s.fc[15:0];
          s.bif = s.bif + 4'd1;
          if (s.bif >= 4'd12) begin
            s.bif = '0;
            s.p   = (s.sl != '0) ? PH_STRIP_HDR : PH_FRAME_TAIL;
          end
        end
        PH_STRIP_HDR: begin
          if (s.bif < 4'd4) s.fc = {s.fc[39:0], b};
          else s.sb = {s.sb[55:0], b};
          id = s.fc[31:16];
          n  = s.fc[15:0];
          if (s.bif == 4'd3 && id != STRIP_ID_KEY && id != STRIP_ID_INTER) begin
            // Bad strip type: the strip is skipped and not stacked.
            emit_c          = 1'b1;
            cmd_c.stat_vld  = 1'b1;
            cmd_c.stat_code = SC_BAD_STRIP;
            s.sbl           = (n > 16'd4) ? n - 16'd4 : 16'd0;
            s               = f_skip_or_end(s);
          end else begin
            if (s.bif == 4'd3) s.sbl = (n > 16'd12) ? n - 16'd12 : 16'd0;
            s.bif = s.bif + 4'd1;
            if (s.bif >= 4'd12) begin
              if (s.sbl == '0) s = f_strip_end(s, 1'b1);
              else begin
                s.p   = PH_CHUNK_HDR;
                s.bif = '0;
              end
            end
          end
        end
        PH_CHUNK_HDR: begin
          s.fc = {s.fc[39:0], b};
          if (s.sbl != '0) s.sbl = s.sbl - 16'd1;
          s.bif = s.bif + 4'd1;
          id    = s.fc[31:16];
          n     = s.fc[15:0];
          if (s.bif >= 4'd4) begin
            if (n < 16'd4) begin
              emit_c          = 1'b1;
              cmd_c.stat_vld  = 1'b1;
              cmd_c.stat_code = SC_SHORT;
              s               = f_skip_or_end(s);
            end else if (n - 16'd4 > s.sbl) begin
              emit_c          = 1'b1;
              cmd_c.stat_vld  = 1'b1;
              cmd_c.stat_code = SC_LONG;
              s               = f_skip_or_end(s);
            end else begin
              // Start of a chunk body.
              s.ck  = id;
              s.cbl = n - 16'd4;
              s.bif = '0;
              s.ci  = '0;
              s.fr  = '0;
              s.fb  = '0;
              s.cx  = {1'b0, s.sb[47:32]};
              sum   = {1'b0, s.sb[63:48]} + {1'b0, s.rs};
              s.cy  = (32'(sum) >= 32'(FB_WORDS)) ? CY_W'(FB_WORDS) : CY_W'(sum);
              case (kind_class(id))
                CL_UNKNOWN: begin
                  emit_c          = 1'b1;
                  cmd_c.stat_vld  = 1'b1;
                  cmd_c.stat_code = SC_UNKNOWN;
                  s.p             = PH_CHUNK_SKIP;
                end
                CL_FULL:   s.p = PH_ENTRY;
                CL_V1ONLY: s.p = PH_V1;
                default:   s.p = PH_FLAGS;
              endcase
              if (s.cbl == '0) s = f_chunk_end(s);
            end
          end else if (s.sbl == '0) begin
            emit_c          = 1'b1;
            cmd_c.stat_vld  = 1'b1;
            cmd_c.stat_code = SC_LONG;
            s               = f_strip_end(s, 1'b0);
          end
        end
        PH_FLAGS, PH_V4_FLAGS, PH_ENTRY, PH_V1, PH_V4, PH_CHUNK_SKIP: begin
          if (s.sbl != '0) s.sbl = s.sbl - 16'd1;
          if (s.cbl != '0) s.cbl = s.cbl - 16'd1;
          case (s.p)
            PH_FLAGS, PH_V4_FLAGS: begin
              s.fc  = {s.fc[39:0], b};
              s.bif = s.bif + 4'd1;
              if (s.bif == 4'd4) begin
                s.fb  = s.fc[31:0];
                s.fr  = 6'd32;
                s.bif = '0;
                if (s.p == PH_V4_FLAGS) begin
                  pb   = s.fb[31];
                  s.fb = {s.fb[30:0], 1'b0};
                  s.fr = s.fr - 6'd1;
                  s.p  = pb ? PH_V4 : PH_V1;
                end else begin
                  nb = 1'b1;
                end
              end
            end
            PH_ENTRY: begin
              s.fc  = {s.fc[39:0], b};
              s.bif = s.bif + 4'd1;
              if (s.bif >= size) begin
                if (s.ci < (CB_AW + 1)'(CODEBOOK_ENTRIES)) begin
                  emit_c      = 1'b1;
                  cmd_c.op    = OP_CBW;
                  cmd_c.idx   = s.ci[CB_AW-1:0];
                  cmd_c.data  = s.fc;
                  cmd_c.grey  = s.ck[KIND_GREY_BIT];
                  cmd_c.to_v1 = s.ck[KIND_V1_BIT];
                  s.ci        = s.ci + 1'b1;
                end
                s.bif = '0;
                if (kind_class(s.ck) == CL_PART) nb = 1'b1;
              end
            end
            PH_V1: begin
              emit_c     = 1'b1;
              cmd_c.op   = OP_V1;
              cmd_c.data = {40'd0, b};
              cmd_c.cx   = s.cx;
              cmd_c.cy   = s.cy;
              s          = f_advance(s);
              nb         = 1'b1;
            end
            PH_V4: begin
              s.fc  = {s.fc[39:0], b};
              s.bif = s.bif + 4'd1;
              if (s.bif == 4'd4) begin
                emit_c     = 1'b1;
                cmd_c.op   = OP_V4;
                cmd_c.data = {16'd0, s.fc[31:0]};
                cmd_c.cx   = s.cx;
                cmd_c.cy   = s.cy;
                s          = f_advance(s);
                nb         = 1'b1;
              end
            end
            default: begin
            end
          endcase
          if (s.cbl == '0) begin
            s  = f_chunk_end(s);
            nb = 1'b0;
          end
        end
        PH_STRIP_SKIP: begin
          if (s.sbl != '0) s.sbl = s.sbl - 16'd1;
          if (s.sbl == '0) s = f_strip_end(s, 1'b0);
        end
        default: s.p = PH_FRAME_OVER;
      endcase

      // Frame end closes the run and restarts the parser.
      if (in_item.last_byte) begin
        emit_c         = 1'b1;
        cmd_c.end_vld  = 1'b1;
        cmd_c.end_done = (s.p == PH_FRAME_TAIL);
        s              = f_reset();
        nb             = 1'b0;
      end
      walk_nxt = nb;
    end
    st_nxt = s;
  end

  // Handshake and command outputs.
  always_comb begin : parse_out
    full     = walk_r || cmd_full;
    cmd_push = accept && emit_c;
    cmd      = cmd_c;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= f_reset();
      walk_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      walk_r <= walk_nxt;
    end
  end

endmodule

// ===== src/cfd_back.sv =====
// Back end: holds both codebooks, carries out commands and queues results.
// Depends on cfd_pkg.
module cfd_back (
  input  logic               clk,
  input  logic               rst_n,
  input  cfd_pkg::cmd_t      q_head,
  input  logic               q_empty,
  output logic               q_pop,
  input  logic [7:0]         pitch,
  output cfd_pkg::out_item_t out_item,
  output logic               empty,
  input  logic               pop
);
  import cfd_pkg::*;

  localparam int PW = $clog2(OUTQ_DEPTH);
  localparam int CW = $clog2(OUTQ_DEPTH + 1);

  bk_state_t         bk_r, bk_nxt;
  cmd_t              cmd_r;
  logic [1:0]        row_r;
  logic [ADDR_W-1:0] addr_r;
  logic [ADDR_W-1:0] addr_next;
  logic [CY_W+7:0]   mul;
  logic [63:0]       v1_mem [CODEBOOK_ENTRIES];
  logic [63:0]       v4_mem [CODEBOOK_ENTRIES];
  logic [63:0]       v1rd_r, v4a_r, v4b_r;
  logic [CB_AW-1:0]  ra_a, ra_b;
  logic              rd4_en;
  logic [63:0]       entry;
  logic [63:0]       row_word;
  logic              take, adv, opush, in_rng;
  out_item_t         res;
  out_item_t         oq_r [OUTQ_DEPTH];
  logic [PW-1:0]     owp_r, orp_r;
  logic [CW-1:0]     ocnt_r;
  logic              ofull, opop;

  // Codebook entry from four luma values and optional chroma.
  always_comb begin
    if (q_head.grey)
      entry = {yuv565(q_head.data[7:0], 8'd0, 8'd0),
               yuv565(q_head.data[15:8], 8'd0, 8'd0),
               yuv565(q_head.data[23:16], 8'd0, 8'd0),
               yuv565(q_head.data[31:24], 8'd0, 8'd0)};
    else
      entry = {yuv565(q_head.data[23:16], q_head.data[15:8], q_head.data[7:0]),
               yuv565(q_head.data[31:24], q_head.data[15:8], q_head.data[7:0]),
               yuv565(q_head.data[39:32], q_head.data[15:8], q_head.data[7:0]),
               yuv565(q_head.data[47:40], q_head.data[15:8], q_head.data[7:0])};
  end

  // Base address of a block's first line.
  assign mul       = q_head.cy * pitch;
  assign addr_next = addr_r + ADDR_W'(pitch);

  // Codebook read addresses: the second V4 pair is fetched during line one.
  always_comb begin
    ra_a   = take ? q_head.data[31:24] : cmd_r.data[15:8];
    ra_b   = take ? q_head.data[23:16] : cmd_r.data[7:0];
    rd4_en = take || (bk_r == BK_ROWS && row_r == 2'd1 && adv);
  end

  // Pixel word of the current line.
  always_comb begin
    if (cmd_r.op == OP_V1) begin
      if (row_r[1])
        row_word = {v1rd_r[63:48], v1rd_r[63:48], v1rd_r[47:32], v1rd_r[47:32]};
      else
        row_word = {v1rd_r[31:16], v1rd_r[31:16], v1rd_r[15:0], v1rd_r[15:0]};
    end else begin
      if (row_r[0]) row_word = {v4b_r[63:32], v4a_r[63:32]};
      else          row_word = {v4b_r[31:0], v4a_r[31:0]};
    end
  end

  // Sequencer outputs: result to queue and step handshakes.
  always_comb begin : bk_out
    res    = '0;
    opush  = 1'b0;
    adv    = 1'b0;
    take   = 1'b0;
    in_rng = (addr_r < ADDR_W'(FB_WORDS));
    case (bk_r)
      BK_IDLE: take = !q_empty;
      BK_ROWS: begin
        res.result_kind = RK_WRITE;
        res.word_addr   = addr_r[16:0];
        res.pixel_word  = row_word;
        res.last_of_run = !cmd_r.stat_vld && !cmd_r.end_vld &&
                          (row_r == 2'd3 || addr_next >= ADDR_W'(FB_WORDS));
        opush = in_rng && !ofull;
        adv   = !in_rng || !ofull;
      end
      BK_STAT: begin
        res.result_kind = RK_STATUS;
        res.status_code = cmd_r.stat_code;
        res.last_of_run = !cmd_r.end_vld;
        opush           = !ofull;
        adv             = !ofull;
      end
      BK_END: begin
        res.result_kind = cmd_r.end_done ? RK_DONE : RK_STATUS;
        res.status_code = cmd_r.end_done ? SC_OK : SC_LEN_MISMATCH;
        res.last_of_run = 1'b1;
        opush           = !ofull;
        adv             = !ofull;
      end
      default: begin
      end
    endcase
    q_pop = take;
  end

  // Sequencer next state.
  always_comb begin : bk_next
    bk_nxt = bk_r;
    case (bk_r)
      BK_IDLE: begin
        if (take) begin
          if (q_head.op == OP_V1 || q_head.op == OP_V4) bk_nxt = BK_ROWS;
          else if (q_head.stat_vld) bk_nxt = BK_STAT;
          else if (q_head.end_vld) bk_nxt = BK_END;
        end
      end
      BK_ROWS: begin
        if (adv && row_r == 2'd3) begin
          if (cmd_r.stat_vld) bk_nxt = BK_STAT;
          else if (cmd_r.end_vld) bk_nxt = BK_END;
          else bk_nxt = BK_IDLE;
        end
      end
      BK_STAT: if (adv) bk_nxt = cmd_r.end_vld ? BK_END : BK_IDLE;
      BK_END:  if (adv) bk_nxt = BK_IDLE;
      default: bk_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) bk_r <= BK_IDLE;
    else        bk_r <= bk_nxt;
  end

  // Working registers of the current command.
  always_ff @(posedge clk) begin
    if (take) begin
      cmd_r  <= q_head;
      row_r  <= 2'd0;
      addr_r <= ADDR_W'(mul) + ADDR_W'(q_head.cx[16:2]);
    end else if (bk_r == BK_ROWS && adv) begin
      row_r  <= row_r + 2'd1;
      addr_r <= addr_next;
    end
  end

  // Codebook memories with registered reads.
  always_ff @(posedge clk) begin
    if (take && q_head.op == OP_CBW && q_head.to_v1) v1_mem[q_head.idx] <= entry;
    if (take) v1rd_r <= v1_mem[q_head.data[7:0]];
  end

  always_ff @(posedge clk) begin
    if (take && q_head.op == OP_CBW && !q_head.to_v1) v4_mem[q_head.idx] <= entry;
    if (rd4_en) begin
      v4a_r <= v4_mem[ra_a];
      v4b_r <= v4_mem[ra_b];
    end
  end

  // Result queue toward the output port.
  always_comb begin
    ofull    = (ocnt_r == CW'(OUTQ_DEPTH));
    empty    = (ocnt_r == '0);
    opop     = pop && !empty;
    out_item = oq_r[orp_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owp_r  <= '0;
      orp_r  <= '0;
      ocnt_r <= '0;
    end else begin
      if (opush) owp_r <= owp_r + PW'(1);
      if (opop)  orp_r <= orp_r + PW'(1);
      ocnt_r <= ocnt_r + CW'(opush) - CW'(opop);
    end
  end

  always_ff @(posedge clk) begin
    if (opush) oq_r[owp_r] <= res;
  end

endmodule

// ===== src/cinepak_frame_decoder_top.sv =====
// Top level of the frame decoder: pitch register, parser, command queue and
// back end. Depends on cfd_pkg, cfd_front, cfd_cmd_queue and cfd_back.
//
//   Port group        Direction  Transfer condition
//   push/full/in_item in         push high and full low at the clock edge
//   empty/pop/out_item out       pop high and empty low at the clock edge
//   cfg_we/cfg_wdata  in         cfg_we high at the clock edge
//
// The parser takes one byte per cycle while neither a flag walk nor a full command
// queue holds the input. A byte that ends a flag word, a block, or an entry of a
// flag-driven load starts a flag walk, which holds the input while skipped flags are
// walked. The back end reads the codebook as it takes a block command, then writes
// four lines; status or frame end is queued after its take, a codebook write on take.
// Reset (rst_n low, synchronous) empties both queues and restarts the parser.
// Input and output stall independently through the command and result queues.
module cinepak_frame_decoder_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  cfd_pkg::in_item_t  in_item,
  output logic               empty,
  input  logic               pop,
  output cfd_pkg::out_item_t out_item,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_wdata
);
  import cfd_pkg::*;

  logic [7:0] pitch_r;
  logic       cmd_push, cmd_full, cmd_empty, cmd_pop;
  cmd_t       cmd_in, cmd_head;

  // Line pitch configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n)      pitch_r <= PITCH_RESET;
    else if (cfg_we) pitch_r <= cfg_wdata;
  end

  cfd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_item  (in_item),
    .cmd_push (cmd_push),
    .cmd      (cmd_in),
    .cmd_full (cmd_full)
  );

  cfd_cmd_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cmd_push),
    .wr_cmd  (cmd_in),
    .q_full  (cmd_full),
    .rd_en   (cmd_pop),
    .rd_cmd  (cmd_head),
    .q_empty (cmd_empty)
  );

  cfd_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_head   (cmd_head),
    .q_empty  (cmd_empty),
    .q_pop    (cmd_pop),
    .pitch    (pitch_r),
    .out_item (out_item),
    .empty    (empty),
    .pop      (pop)
  );

endmodule
